// ----- sv/encoder_delta_rate_estimator_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the encoder delta rate estimator
// Implication checks, sampled on clk with the synchronous reset masked.
// ----------------------------------------------------------------------------
`ifndef ENCODER_DELTA_RATE_ESTIMATOR_TOP_ASSERT_SVH
`define ENCODER_DELTA_RATE_ESTIMATOR_TOP_ASSERT_SVH

// same-cycle implication
`define EDRE_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);

// next-cycle implication
`define EDRE_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error(msg);

`endif

// ----- sv/encdr_pkg.sv -----
// ----------------------------------------------------------------------------
// encdr_pkg
// Word types, register indexes and constants of the encoder rate estimator.
// ----------------------------------------------------------------------------
package encdr_pkg;

  localparam int unsigned NUM_WHEELS  = 2;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned MIN_INT_W   = 16;
  localparam int unsigned WIN_W       = 10;
  localparam int unsigned MASK_W      = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // |d| <= 32768, window <= 1023: product stays below 2^25
  localparam int unsigned PROD_W      = 25;
  localparam int unsigned DIV_STEPS   = PROD_W;
  localparam int unsigned STEP_W      = $clog2(DIV_STEPS);

  localparam logic signed [CNT_W-1:0] CORR_LIMIT = 16'sd30000;

  localparam logic [MIN_INT_W-1:0] MIN_INT_RST = 16'd40;
  localparam logic [WIN_W-1:0]     WIN_RST     = 10'd50;
  localparam logic [MASK_W-1:0]    MASK_RST    = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEGATE_MASK  = 2'd2;

  typedef struct packed {
    logic              wheel;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic                    updated;
    logic signed [CNT_W-1:0] rate;
  } out_word_t;

endpackage

// ----- sv/encoder_delta_rate_estimator_top.sv -----
// ----------------------------------------------------------------------------
// encoder_delta_rate_estimator_top
// Two-wheel encoder rate estimator with a bit-serial restoring divider.
// ----------------------------------------------------------------------------
// One word in gives one word out. A word that does not pass the minimum
// interval returns the held rate (S_PREP, then S_DONE); a word that
// computes a new rate goes through compare/correct, one 16x10 multiply,
// 25 steps of a one-bit-per-cycle restoring divider, and the write-back.
// S_DONE waits while the output register is full and stalled. A new word is
// taken in the cycle after the result is registered. Only one word is in
// flight; the result sits in an output register, so the next word is taken
// while the previous result waits. A zero elapsed divisor skips the divider
// and gives a rate of 0.
// ----------------------------------------------------------------------------
module encoder_delta_rate_estimator_top
  import encdr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_MUL, S_DIV, S_DONE} state_t;

  state_t                  state_r;
  in_word_t                in_r;
  out_word_t               out_r;
  logic                    out_valid_r;

  logic [MIN_INT_W-1:0]    min_int_r;
  logic [WIN_W-1:0]        win_r;
  logic [MASK_W-1:0]       mask_r;

  logic [CNT_W-1:0]        pcount_r [NUM_WHEELS];
  logic [TIME_W-1:0]       ptime_r  [NUM_WHEELS];
  logic [CNT_W-1:0]        held_r   [NUM_WHEELS];

  logic                    upd_r;
  logic                    neg_r;
  logic [CNT_W-1:0]        dmag_r;
  logic [CNT_W-1:0]        div_r;
  logic [CNT_W-1:0]        rem_r;
  logic [PROD_W-1:0]       quo_r;
  logic [STEP_W-1:0]       step_r;

  logic [TIME_W-1:0]       elapsed;
  logic                    upd_nxt;
  logic signed [CNT_W-1:0] draw;
  logic signed [CNT_W-1:0] dcor;
  logic signed [CNT_W-1:0] dvs;
  logic [CNT_W-1:0]        dmag_nxt;
  logic [CNT_W-1:0]        div_nxt;
  logic [CNT_W+WIN_W-1:0]  prod;
  logic [CNT_W:0]          shifted;
  logic [CNT_W:0]          trial;
  logic [CNT_W-1:0]        rate_nxt;
  logic                    out_free;

  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  // elapsed time and corrected count difference
  always_comb begin
    elapsed = in_r.now_ms - ptime_r[in_r.wheel];
    upd_nxt = (elapsed > {{(TIME_W-MIN_INT_W){1'b0}}, min_int_r});
    draw    = $signed(in_r.count - pcount_r[in_r.wheel]);
    if (draw > CORR_LIMIT) begin
      dcor = draw + 16'sd1;
    end else if (draw < -CORR_LIMIT) begin
      dcor = draw - 16'sd1;
    end else begin
      dcor = draw;
    end
    dvs      = $signed(elapsed[CNT_W-1:0]);
    dmag_nxt = dcor[CNT_W-1] ? (~dcor + 16'sd1) : dcor;
    div_nxt  = dvs[CNT_W-1] ? (~dvs + 16'sd1) : dvs;
  end

  assign prod    = dmag_r * win_r;
  assign shifted = {rem_r, quo_r[PROD_W-1]};
  assign trial   = shifted - {1'b0, div_r};
  assign rate_nxt = neg_r ? (~quo_r[CNT_W-1:0] + 16'd1) : quo_r[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      min_int_r   <= MIN_INT_RST;
      win_r       <= WIN_RST;
      mask_r      <= MASK_RST;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        pcount_r[i] <= '0;
        ptime_r[i]  <= '0;
        held_r[i]   <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_MIN_INTERVAL: min_int_r <= cfg_wdata[MIN_INT_W-1:0];
          CFG_WINDOW:       win_r     <= cfg_wdata[WIN_W-1:0];
          CFG_NEGATE_MASK:  mask_r    <= cfg_wdata[MASK_W-1:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r    <= in_word;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          upd_r  <= upd_nxt;
          dmag_r <= dmag_nxt;
          div_r  <= div_nxt;
          neg_r  <= dcor[CNT_W-1] ^ dvs[CNT_W-1] ^ mask_r[in_r.wheel];
          state_r <= upd_nxt ? S_MUL : S_DONE;
        end
        S_MUL: begin
          rem_r  <= '0;
          step_r <= STEP_W'(DIV_STEPS - 1);
          if (div_r == '0) begin
            quo_r   <= '0;
            state_r <= S_DONE;
          end else begin
            quo_r   <= prod[PROD_W-1:0];
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (!trial[CNT_W]) begin
            rem_r <= trial[CNT_W-1:0];
            quo_r <= {quo_r[PROD_W-2:0], 1'b1};
          end else begin
            rem_r <= shifted[CNT_W-1:0];
            quo_r <= {quo_r[PROD_W-2:0], 1'b0};
          end
          step_r <= step_r - 1'b1;
          if (step_r == '0) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_r.updated <= upd_r;
            if (upd_r) begin
              out_r.rate               <= $signed(rate_nxt);
              held_r[in_r.wheel]   <= rate_nxt;
              pcount_r[in_r.wheel] <= in_r.count;
              ptime_r[in_r.wheel]  <= in_r.now_ms;
            end else begin
              out_r.rate <= $signed(held_r[in_r.wheel]);
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`include "encoder_delta_rate_estimator_top_assert.svh"

  `EDRE_ASSERT_IMP(a_rem_below_div, state_r == S_DIV, rem_r < div_r, "remainder not below divisor")
  `EDRE_ASSERT_NXT(a_accept_to_prep, in_valid && !in_stall, state_r == S_PREP, "accepted word not taken up")
  `EDRE_ASSERT_NXT(a_done_waits, state_r == S_DONE && out_valid_r && out_stall, state_r == S_DONE && out_valid_r, "result overwrote waiting word")
  `EDRE_ASSERT_NXT(a_hold_rate, state_r == S_DONE && out_free && !upd_r, out_r.rate == $signed(held_r[in_r.wheel]) && !out_r.updated, "held rate not returned")

endmodule
